// ===== hw/rtl/tpc_pkg.sv =====
package tpc_pkg;

  localparam int MAX_CHANNELS = 32;
  localparam int MAX_ROWS     = 256;
  localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ROW_W        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int FIELD_COUNT  = 5;

  // field slots, lowest byte of a cell first
  localparam int F_NOTE  = 0;
  localparam int F_INSTR = 1;
  localparam int F_VOL   = 2;
  localparam int F_CMD   = 3;
  localparam int F_PARAM = 4;

  localparam logic [2:0] OP_ADVANCE_ROWS  = 3'd7;
  localparam int         ROWS_PER_ADVANCE = 32;
  localparam logic [7:0] VOLUME_BASE      = 8'h10;
  localparam logic [7:0] ADV_FULL_BYTE    = 8'hFF;

  // configuration register indexes
  localparam logic [2:0] CFG_NUM_ROWS       = 3'd0;
  localparam logic [2:0] CFG_NUM_CHANNELS   = 3'd1;
  localparam logic [2:0] CFG_EMPTY_CODE     = 3'd2;
  localparam logic [2:0] CFG_NOTE_OFF_CODE  = 3'd3;
  localparam logic [2:0] CFG_OP_CHAN_ADV    = 3'd4;
  localparam logic [2:0] CFG_OP_USE_CACHES  = 3'd5;
  localparam logic [2:0] CFG_OP_READ_FIELDS = 3'd6;
  localparam logic [2:0] CFG_OP_END_PATTERN = 3'd7;

  localparam logic [8:0] NUM_ROWS_RST       = 9'd64;
  localparam logic [5:0] NUM_CHANNELS_RST   = 6'd8;
  localparam logic [7:0] EMPTY_CODE_RST     = 8'd255;
  localparam logic [7:0] NOTE_OFF_CODE_RST  = 8'd97;
  localparam logic [2:0] OP_CHAN_ADV_RST    = 3'd0;
  localparam logic [2:0] OP_USE_CACHES_RST  = 3'd1;
  localparam logic [2:0] OP_READ_FIELDS_RST = 3'd2;
  localparam logic [2:0] OP_END_PATTERN_RST = 3'd3;

  typedef logic [FIELD_COUNT-1:0][7:0] tpc_fields_t;
  typedef logic [FIELD_COUNT-1:0]      tpc_mask_t;

  typedef struct packed {
    logic            rd_en;
    logic            wr_en;
    logic            clear;
    logic [CH_W-1:0] addr;
    tpc_fields_t     wr_data;
  } tpc_cache_req_t;

endpackage

// ===== hw/rtl/tpc_field_cache.sv =====
module tpc_field_cache (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tpc_pkg::tpc_cache_req_t req,
  input  logic [7:0]             empty_code,
  output tpc_pkg::tpc_fields_t   rd_data
);

  tpc_pkg::tpc_fields_t            mem [tpc_pkg::MAX_CHANNELS];
  tpc_pkg::tpc_fields_t            mem_q;
  logic [tpc_pkg::MAX_CHANNELS-1:0] valid_r;
  logic                            vld_q;
  logic [7:0]                      clr_code_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q <= mem[req.addr];
      vld_q <= valid_r[req.addr];
    end
  end

  // valid bits stand in for a clearing pass; a stale entry reads as the code of the last clear, with a zero parameter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      clr_code_r <= tpc_pkg::EMPTY_CODE_RST;
    end else if (req.clear) begin
      valid_r    <= '0;
      clr_code_r <= empty_code;
    end else if (req.wr_en) begin
      valid_r[req.addr] <= 1'b1;
    end
  end

  always_comb begin
    rd_data = mem_q;
    if (!vld_q) begin
      for (int i = 0; i < tpc_pkg::FIELD_COUNT; i++) begin
        rd_data[i] = (i == tpc_pkg::F_PARAM) ? 8'd0 : clr_code_r;
      end
    end
  end

endmodule

// ===== hw/rtl/tracker_pattern_compressor.sv =====
// Tracker pattern compressor.
//
// Cells enter on the in_ stream in row-major order, one transfer per cell;
// in_tdata packs note, instrument, volume, command and parameter_req.
// Compressed bytes leave on the out_ stream, one byte per transfer, with
// out_tlast marking the final byte that a cell causes. A cell that is empty
// and does not close the pattern causes no transfer at all.
// The cfg_ port writes the eight registers; write it only while idle.
//
// Flow: the input transfer reads the cell's channel entry from the cache
// RAM; the compare state checks the cell against it and writes it back;
// after that the byte sequencer loads one byte per cycle into the output
// register while the receiver is not stalling. in_tready is high only
// while no cell is in work, so one cell at a time is handled. A stalled
// receiver freezes the sequencer; the held byte stays in place.
//
// Reset: registers take their default values, the position counters clear
// and every cache entry reads as empty at once (valid bits, no sweep).
module tracker_pattern_compressor (
  input  logic        clk,
  input  logic        rst_n,
  // input cells
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // note, instrument, volume, command, parameter_req
  // compressed bytes
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte
  output logic        out_tlast,  // is_last
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [8:0]  cfg_data
);

  localparam int CH_W  = tpc_pkg::CH_W;
  localparam int ROW_W = tpc_pkg::ROW_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CMP, S_ADV, S_CHAN, S_USE, S_RDF, S_VAL, S_END
  } state_t;

  // pick the first pending byte kind after the current one
  function automatic state_t pick_next(input logic chan, input logic use_c,
                                       input logic rd, input logic ende);
    state_t s;
    if (chan)       s = S_CHAN;
    else if (use_c) s = S_USE;
    else if (rd)    s = S_RDF;
    else if (ende)  s = S_END;
    else            s = S_IDLE;
    return s;
  endfunction

  // configuration registers
  logic [8:0] num_rows_r;
  logic [5:0] num_chans_r;
  logic [7:0] empty_code_r;
  logic [7:0] note_off_r;
  logic [2:0] op_chan_adv_r;
  logic [2:0] op_use_r;
  logic [2:0] op_rd_r;
  logic [2:0] op_end_r;

  // position state
  logic [ROW_W-1:0] row_r;
  logic [CH_W-1:0]  ch_r;
  logic [ROW_W-1:0] last_row_r;
  logic             lc0_r;       // last channel is zero (else "none")

  // per-cell work registers
  state_t               state_r, state_nxt;
  tpc_pkg::tpc_fields_t fields_r;
  tpc_pkg::tpc_mask_t   use_mask_r, rem_r;
  logic [ROW_W-1:0]     cell_row_r, adv_row_r;
  logic                 need_chan_r, need_use_r, need_rd_r, need_end_r;
  logic [7:0]           chan_byte_r, rd_byte_r;

  logic       out_valid_r, out_last_r;
  logic [7:0] out_byte_r;

  tpc_pkg::tpc_cache_req_t cache_req;
  tpc_pkg::tpc_fields_t    cache_q, clean, in_f, merged;
  tpc_pkg::tpc_mask_t      hit_c, new_c, rem_nxt;

  logic             in_fire, out_free, emit_go;
  logic [7:0]       emit_byte;
  logic [8:0]       rows_eff;
  logic [5:0]       chans_eff;
  logic             any_c, arb_c, adv_go_c, need_chan_c, wrap_c, need_end_c;
  logic [ROW_W-1:0] adv_diff, adv_nxt;
  logic [2:0]       val_idx;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_free   = !out_valid_r || out_tready;

  // out-of-range counts saturate
  always_comb begin
    if (num_rows_r == 9'd0)                       rows_eff = 9'd1;
    else if (num_rows_r > 9'(tpc_pkg::MAX_ROWS))  rows_eff = 9'(tpc_pkg::MAX_ROWS);
    else                                          rows_eff = num_rows_r;
    if (num_chans_r == 6'd0)                          chans_eff = 6'd1;
    else if (num_chans_r > 6'(tpc_pkg::MAX_CHANNELS)) chans_eff = 6'(tpc_pkg::MAX_CHANNELS);
    else                                              chans_eff = num_chans_r;
  end

  // clean the raw cell as it arrives
  always_comb begin
    in_f = tpc_pkg::tpc_fields_t'(in_tdata);
    clean = in_f;
    if (in_f[tpc_pkg::F_NOTE] > note_off_r) clean[tpc_pkg::F_NOTE] = empty_code_r;
    clean[tpc_pkg::F_INSTR] = (in_f[tpc_pkg::F_INSTR] == 8'd0) ? empty_code_r
                              : in_f[tpc_pkg::F_INSTR] - 8'd1;
    clean[tpc_pkg::F_VOL] = (in_f[tpc_pkg::F_VOL] < tpc_pkg::VOLUME_BASE) ? empty_code_r
                            : in_f[tpc_pkg::F_VOL] - tpc_pkg::VOLUME_BASE;
    if (in_f[tpc_pkg::F_CMD] == 8'd0 && in_f[tpc_pkg::F_PARAM] == 8'd0) begin
      clean[tpc_pkg::F_CMD] = empty_code_r;
    end
  end

  // compare against the cache entry and decide the byte plan
  always_comb begin
    for (int i = 0; i < tpc_pkg::FIELD_COUNT; i++) begin
      logic present;
      present = (i == tpc_pkg::F_PARAM) ? (fields_r[i] != 8'd0)
                                        : (fields_r[i] != empty_code_r);
      hit_c[i]  = present && (fields_r[i] == cache_q[i]);
      new_c[i]  = present && (fields_r[i] != cache_q[i]);
      merged[i] = new_c[i] ? fields_r[i] : cache_q[i];
    end
    any_c    = (hit_c != '0) || (new_c != '0);
    arb_c    = (row_r != '0) && (last_row_r == row_r - 1'b1) && !(lc0_r && ch_r == '0);
    adv_go_c = any_c && !arb_c && (last_row_r < row_r);
    if (arb_c)         need_chan_c = any_c;
    else if (adv_go_c) need_chan_c = (ch_r != '0);
    else               need_chan_c = any_c && !(lc0_r && ch_r == '0);
    wrap_c     = (6'(ch_r) + 6'd1) >= chans_eff;
    need_end_c = wrap_c && ((9'(row_r) + 9'd1) >= rows_eff);
  end

  // row advance step and value pick
  always_comb begin
    adv_diff = cell_row_r - adv_row_r;
    if (9'(adv_diff) > 9'(tpc_pkg::ROWS_PER_ADVANCE)) begin
      adv_nxt = ROW_W'(9'(adv_row_r) + 9'(tpc_pkg::ROWS_PER_ADVANCE));
    end else begin
      adv_nxt = cell_row_r;
    end
    val_idx = 3'd0;
    for (int i = tpc_pkg::FIELD_COUNT - 1; i >= 0; i--) begin
      if (rem_r[i]) val_idx = 3'(i);
    end
    rem_nxt = rem_r & (rem_r - 1'b1);
  end

  always_comb begin
    state_nxt = state_r;
    emit_byte = 8'd0;
    emit_go   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_CMP;
      end
      S_CMP: begin
        if (any_c) begin
          state_nxt = adv_go_c ? S_ADV
                    : pick_next(need_chan_c, hit_c != '0, new_c != '0, need_end_c);
        end else begin
          state_nxt = pick_next(1'b0, 1'b0, 1'b0, need_end_c);
        end
      end
      S_ADV: begin
        if (9'(adv_diff) > 9'(tpc_pkg::ROWS_PER_ADVANCE)) begin
          emit_byte = tpc_pkg::ADV_FULL_BYTE;
        end else begin
          emit_byte = {tpc_pkg::OP_ADVANCE_ROWS, 5'(9'(adv_diff) - 9'd1)};
        end
        emit_go = out_free;
        if (out_free) begin
          state_nxt = (adv_nxt < cell_row_r) ? S_ADV
                    : pick_next(need_chan_r, need_use_r, need_rd_r, need_end_r);
        end
      end
      S_CHAN: begin
        emit_byte = chan_byte_r;
        emit_go   = out_free;
        if (out_free) state_nxt = pick_next(1'b0, need_use_r, need_rd_r, need_end_r);
      end
      S_USE: begin
        emit_byte = {op_use_r, use_mask_r};
        emit_go   = out_free;
        if (out_free) state_nxt = pick_next(1'b0, 1'b0, need_rd_r, need_end_r);
      end
      S_RDF: begin
        emit_byte = rd_byte_r;
        emit_go   = out_free;
        if (out_free) state_nxt = S_VAL;
      end
      S_VAL: begin
        emit_byte = fields_r[val_idx];
        emit_go   = out_free;
        if (out_free) begin
          state_nxt = (rem_nxt != '0) ? S_VAL : pick_next(1'b0, 1'b0, 1'b0, need_end_r);
        end
      end
      S_END: begin
        emit_byte = {op_end_r, 5'd0};
        emit_go   = out_free;
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cache_req.rd_en   = in_fire;
    cache_req.wr_en   = (state_r == S_CMP) && any_c;
    cache_req.clear   = (state_r == S_CMP) && need_end_c;
    cache_req.addr    = ch_r;
    cache_req.wr_data = merged;
  end

  tpc_field_cache u_cache (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (cache_req),
    .empty_code (empty_code_r),
    .rd_data    (cache_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r    <= tpc_pkg::NUM_ROWS_RST;
      num_chans_r   <= tpc_pkg::NUM_CHANNELS_RST;
      empty_code_r  <= tpc_pkg::EMPTY_CODE_RST;
      note_off_r    <= tpc_pkg::NOTE_OFF_CODE_RST;
      op_chan_adv_r <= tpc_pkg::OP_CHAN_ADV_RST;
      op_use_r      <= tpc_pkg::OP_USE_CACHES_RST;
      op_rd_r       <= tpc_pkg::OP_READ_FIELDS_RST;
      op_end_r      <= tpc_pkg::OP_END_PATTERN_RST;
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      row_r         <= '0;
      ch_r          <= '0;
      last_row_r    <= '0;
      lc0_r         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          tpc_pkg::CFG_NUM_ROWS:       num_rows_r    <= cfg_data;
          tpc_pkg::CFG_NUM_CHANNELS:   num_chans_r   <= cfg_data[5:0];
          tpc_pkg::CFG_EMPTY_CODE:     empty_code_r  <= cfg_data[7:0];
          tpc_pkg::CFG_NOTE_OFF_CODE:  note_off_r    <= cfg_data[7:0];
          tpc_pkg::CFG_OP_CHAN_ADV:    op_chan_adv_r <= cfg_data[2:0];
          tpc_pkg::CFG_OP_USE_CACHES:  op_use_r      <= cfg_data[2:0];
          tpc_pkg::CFG_OP_READ_FIELDS: op_rd_r       <= cfg_data[2:0];
          tpc_pkg::CFG_OP_END_PATTERN: op_end_r      <= cfg_data[2:0];
          default: ;
        endcase
      end

      state_r <= state_nxt;

      // output register: load a byte, or drop the held one once taken
      if (emit_go) begin
        out_valid_r <= 1'b1;
        out_byte_r  <= emit_byte;
        out_last_r  <= (state_nxt == S_IDLE);
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (in_fire) begin
        fields_r <= clean;
      end

      if (state_r == S_CMP) begin
        use_mask_r  <= hit_c;
        rem_r       <= new_c;
        need_chan_r <= need_chan_c;
        need_use_r  <= hit_c != '0;
        need_rd_r   <= new_c != '0;
        need_end_r  <= need_end_c;
        cell_row_r  <= row_r;
        adv_row_r   <= last_row_r;
        chan_byte_r <= {arb_c ? op_chan_adv_r : 3'd0, 5'(ch_r)};
        rd_byte_r   <= {op_rd_r, new_c};
        // position bookkeeping happens here; the sequencer works from copies
        if (need_end_c) begin
          row_r      <= '0;
          ch_r       <= '0;
          last_row_r <= '0;
          lc0_r      <= 1'b0;
        end else begin
          if (any_c && (arb_c || adv_go_c)) last_row_r <= row_r;
          if (adv_go_c) lc0_r <= 1'b1;
          if (wrap_c) begin
            ch_r  <= '0;
            row_r <= row_r + 1'b1;
          end else begin
            ch_r <= ch_r + 1'b1;
          end
        end
      end

      if (state_r == S_ADV && emit_go) adv_row_r <= adv_nxt;
      if (state_r == S_VAL && emit_go) rem_r <= rem_nxt;
    end
  end

endmodule

// ===== hw/rtl/tpc_checker.sv =====
module tpc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // a stalled byte holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output byte changed while stalled");

  // one cell at a time: a cell transfer closes the input for the next cycle
  a_one_cell: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted a second cell back to back");

  // a cell's byte run still open means the block is busy
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready while a byte run is unfinished");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind tracker_pattern_compressor tpc_checker u_tpc_checker (.*);

// ===== tb/tb_tracker_pattern_compressor.sv =====
`timescale 1ns / 1ps

module tb_tracker_pattern_compressor;
  import tpc_pkg::*;

  // one expected byte of the compressed stream
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  typedef enum {CELL_EMPTY, CELL_REPEAT, CELL_RANDOM, CELL_MIXED} cell_kind_t;
  typedef enum {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PULSE} rx_mode_t;

  // Predict the byte stream from accepted cells and check each output transfer
  // against the oldest predicted byte.
  class pattern_stream_board;
    logic [8:0]   rows_reg;
    logic [5:0]   chans_reg;
    logic [7:0]   empty_reg;
    logic [7:0]   note_off_reg;
    logic [2:0]   op_adv_reg;
    logic [2:0]   op_cache_reg;
    logic [2:0]   op_read_reg;
    logic [2:0]   op_end_reg;
    logic [7:0]   sent_fields [MAX_CHANNELS][FIELD_COUNT];
    int unsigned  row_pos;
    int unsigned  chan_pos;
    int unsigned  last_row;
    int           last_chan;
    stream_byte_t pending_bytes [$];
    int           fault_count;

    function new();
      rows_reg     = NUM_ROWS_RST;
      chans_reg    = NUM_CHANNELS_RST;
      empty_reg    = EMPTY_CODE_RST;
      note_off_reg = NOTE_OFF_CODE_RST;
      op_adv_reg   = OP_CHAN_ADV_RST;
      op_cache_reg = OP_USE_CACHES_RST;
      op_read_reg  = OP_READ_FIELDS_RST;
      op_end_reg   = OP_END_PATTERN_RST;
      fault_count  = 0;
      clear_pattern();
    endfunction

    // refill the caches with the current empty code and rewind the position
    function void clear_pattern();
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        for (int i = 0; i < FIELD_COUNT; i++) begin
          sent_fields[c][i] = (i == F_PARAM) ? 8'h00 : empty_reg;
        end
      end
      row_pos   = 0;
      chan_pos  = 0;
      last_row  = 0;
      last_chan = -1;
    endfunction

    function void write_reg(logic [2:0] idx, logic [8:0] val);
      case (idx)
        CFG_NUM_ROWS:       rows_reg     = val;
        CFG_NUM_CHANNELS:   chans_reg    = val[5:0];
        CFG_EMPTY_CODE:     empty_reg    = val[7:0];
        CFG_NOTE_OFF_CODE:  note_off_reg = val[7:0];
        CFG_OP_CHAN_ADV:    op_adv_reg   = val[2:0];
        CFG_OP_USE_CACHES:  op_cache_reg = val[2:0];
        CFG_OP_READ_FIELDS: op_read_reg  = val[2:0];
        CFG_OP_END_PATTERN: op_end_reg   = val[2:0];
        default: ;
      endcase
    endfunction

    function void accept_cell(logic [39:0] cell_bits);
      int unsigned rows;
      int unsigned chans;
      int unsigned row;
      int unsigned ch;
      int unsigned diff;
      logic [7:0]  f [FIELD_COUNT];
      logic [7:0]  none;
      logic [7:0]  e;
      logic [7:0]  arb;
      tpc_mask_t   hit;
      tpc_mask_t   fresh;
      logic [7:0]  bytes [$];

      rows  = rows_reg;
      chans = chans_reg;
      if (rows < 1) rows = 1;
      if (rows > MAX_ROWS) rows = MAX_ROWS;
      if (chans < 1) chans = 1;
      if (chans > MAX_CHANNELS) chans = MAX_CHANNELS;
      row   = row_pos;
      ch    = chan_pos % MAX_CHANNELS;
      e     = empty_reg;
      hit   = '0;
      fresh = '0;

      for (int i = 0; i < FIELD_COUNT; i++) f[i] = cell_bits[8*i +: 8];

      // clean the raw fields: anything meaning "none" becomes the empty code
      if (f[F_NOTE] > note_off_reg) f[F_NOTE] = e;
      f[F_INSTR] = (f[F_INSTR] == 8'h00) ? e : f[F_INSTR] - 8'd1;
      f[F_VOL]   = (f[F_VOL] < VOLUME_BASE) ? e : f[F_VOL] - VOLUME_BASE;
      if (f[F_CMD] == 8'h00 && f[F_PARAM] == 8'h00) f[F_CMD] = e;

      for (int i = 0; i < FIELD_COUNT; i++) begin
        none = (i == F_PARAM) ? 8'h00 : e;
        if (f[i] != none) begin
          if (f[i] == sent_fields[ch][i]) begin
            hit[i] = 1'b1;
          end else begin
            fresh[i] = 1'b1;
            sent_fields[ch][i] = f[i];
          end
        end
      end

      if (hit != '0 || fresh != '0) begin
        arb = 8'h00;
        if (row > 0 && last_row == row - 1 && last_chan != int'(ch)) begin
          // one row down: fold the advance into the channel byte
          arb      = {op_adv_reg, 5'd0};
          last_row = row;
        end else begin
          while (last_row < row) begin
            diff = row - last_row;
            if (diff > ROWS_PER_ADVANCE) begin
              bytes.push_back(ADV_FULL_BYTE);
              last_row += ROWS_PER_ADVANCE;
            end else begin
              bytes.push_back({OP_ADVANCE_ROWS, 5'(diff - 1)});
              last_row += diff;
            end
            last_chan = 0;
          end
        end
        // the channel select never updates last_chan
        if (last_chan != int'(ch)) bytes.push_back(arb | {3'b000, 5'(ch)});
        if (hit != '0) bytes.push_back({op_cache_reg, hit});
        if (fresh != '0) begin
          bytes.push_back({op_read_reg, fresh});
          for (int i = 0; i < FIELD_COUNT; i++) begin
            if (fresh[i]) bytes.push_back(sent_fields[ch][i]);
          end
        end
      end

      chan_pos++;
      if (chan_pos >= chans) begin
        chan_pos = 0;
        row_pos++;
        if (row_pos >= rows) begin
          bytes.push_back({op_end_reg, 5'd0});
          clear_pattern();
        end
      end

      foreach (bytes[i]) pending_bytes.push_back({bytes[i], 1'(i == bytes.size() - 1)});
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      stream_byte_t want;
      if (pending_bytes.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected byte: got %02h last %0b", data, last);
      end else begin
        want = pending_bytes.pop_front();
        if (want.data !== data || want.last !== last) begin
          fault_count++;
          if (fault_count <= 10)
            $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                     want.data, want.last, data, last);
        end
      end
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_addr   = CFG_NUM_ROWS;
  logic [8:0]  cfg_data   = '0;

  pattern_stream_board sb;

  // last non-empty raw cell per channel, replayed to provoke cache hits
  logic [39:0] last_raw [MAX_CHANNELS] = '{default: '0};

  rx_mode_t    rx_mode  = RX_OPEN;
  int unsigned rx_left  = 0;
  int unsigned rx_phase = 0;

  tracker_pattern_compressor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: switch between stall patterns whenever a stretch runs out,
  // including stretches where it never stalls.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode  <= rx_mode_t'($urandom_range(0, 3));
      rx_left  <= $urandom_range(50, 250);
      rx_phase <= 0;
    end else begin
      rx_left  <= rx_left - 1;
      rx_phase <= rx_phase + 1;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
      RX_MOSTLY: out_tready <= ($urandom_range(0, 9) != 0);
      RX_PULSE:  out_tready <= ((rx_phase % 7) < 3);
      default:   out_tready <= 1'b1;
    endcase
  end

  // Check every output transfer at the edge that completes it.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_byte(out_tdata, out_tlast);
  end

  function automatic logic [39:0] cell_of(logic [7:0] note, logic [7:0] instr,
                                          logic [7:0] vol, logic [7:0] cmd,
                                          logic [7:0] par);
    return {par, cmd, vol, instr, note};
  endfunction

  // Build a cell for channel ch under the current cleaning settings.
  function automatic logic [39:0] make_cell(cell_kind_t kind, int unsigned ch);
    logic [7:0]  f [FIELD_COUNT];
    logic [7:0]  e;
    int          sel;
    int          pos;
    logic [39:0] cell_bits;
    e = sb.empty_reg;
    case (kind)
      CELL_REPEAT: begin
        cell_bits = last_raw[ch];
        if ($urandom_range(0, 2) == 0) begin
          pos = $urandom_range(0, FIELD_COUNT - 1);
          cell_bits[8*pos +: 8] = 8'($urandom);
        end
      end
      CELL_RANDOM: cell_bits = {8'($urandom), 32'($urandom)};
      default: begin
        for (int i = 0; i < FIELD_COUNT; i++) begin
          sel = (kind == CELL_EMPTY) ? 1 : $urandom_range(0, 2);
          case (sel)
            0: f[i] = 8'($urandom);
            1: begin
              // a raw value that cleans to "none"
              case (i)
                F_NOTE:  f[i] = (sb.note_off_reg < 8'hFF) ?
                                8'($urandom_range(sb.note_off_reg + 1, 255)) : e;
                F_VOL:   f[i] = 8'($urandom_range(0, 15));
                default: f[i] = 8'h00;
              endcase
            end
            default: begin
              // a raw value that cleans to exactly the empty code
              case (i)
                F_INSTR: f[i] = e + 8'd1;
                F_VOL:   f[i] = e + VOLUME_BASE;
                default: f[i] = e;
              endcase
            end
          endcase
        end
        cell_bits = {f[F_PARAM], f[F_CMD], f[F_VOL], f[F_INSTR], f[F_NOTE]};
      end
    endcase
    if (kind != CELL_EMPTY) last_raw[ch] = cell_bits;
    return cell_bits;
  endfunction

  // Present a cell and hold it until the block takes the transfer.
  task automatic send_cell(logic [39:0] cell_bits);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= cell_bits;
    do @(posedge clk); while (!in_tready);
    sb.accept_cell(cell_bits);
  endtask

  // Drop valid between bursts, for a gap set by n.
  task automatic hold_off(int unsigned n);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Drain every predicted byte, then let the block settle after cells
  // that cause no transfer.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [8:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  // Write all eight registers back to back; unused upper data bits get noise.
  task automatic configure(int rows, int chans, int e, int note_off,
                           int op_adv, int op_cache, int op_read, int op_end);
    cfg_write(CFG_NUM_ROWS,       9'(rows));
    cfg_write(CFG_NUM_CHANNELS,   {3'($urandom), 6'(chans)});
    cfg_write(CFG_EMPTY_CODE,     {1'($urandom), 8'(e)});
    cfg_write(CFG_NOTE_OFF_CODE,  {1'($urandom), 8'(note_off)});
    cfg_write(CFG_OP_CHAN_ADV,    {6'($urandom), 3'(op_adv)});
    cfg_write(CFG_OP_USE_CACHES,  {6'($urandom), 3'(op_cache)});
    cfg_write(CFG_OP_READ_FIELDS, {6'($urandom), 3'(op_read)});
    cfg_write(CFG_OP_END_PATTERN, {6'($urandom), 3'(op_end)});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_rows();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1;
      2:       return MAX_ROWS;
      3:       return 511;
      4:       return $urandom_range(2, 40);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic int pick_chans();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1;
      2:       return MAX_CHANNELS;
      3:       return 63;
      4:       return $urandom_range(33, 62);
      default: return $urandom_range(1, 5);
    endcase
  endfunction

  function automatic int pick_code();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  initial begin
    int          p_empty;
    int          n_items;
    int          burst_left;
    int          gap;
    int          r;
    cell_kind_t  kind;

    sb = new();

    // hold reset, then release on a falling edge
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, two rows of eight channels. Cover field
    // extremes, note and volume boundaries, command 0 with a parameter,
    // empty cells, cache hits and the one-row-down advance flag.
    send_cell(cell_of(8'h00, 8'h01, 8'h10, 8'h00, 8'h01));
    send_cell(cell_of(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_cell(cell_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_cell(cell_of(8'd97, 8'h00, 8'h0F, 8'h00, 8'h00));
    send_cell(cell_of(8'd98, 8'h00, 8'h0F, 8'h00, 8'h00));
    send_cell(cell_of(8'h30, 8'h80, 8'h50, 8'h0F, 8'h00));
    send_cell(cell_of(8'd98, 8'h00, 8'h00, 8'h00, 8'h00));
    send_cell(cell_of(8'h0C, 8'h05, 8'h40, 8'h0F, 8'h80));
    send_cell(cell_of(8'h00, 8'h01, 8'h10, 8'h00, 8'h01));
    send_cell(cell_of(8'hFF, 8'hFF, 8'hFF, 8'h01, 8'hFF));
    repeat (5) send_cell(cell_of(8'd98, 8'h00, 8'h00, 8'h00, 8'h00));
    send_cell(cell_of(8'h0D, 8'h05, 8'h40, 8'h0F, 8'h81));

    // Directed: one-row patterns of two channels, empty code 0, all opcodes 7.
    // Fields that clean to the empty code are dropped, and a pattern that
    // closes on an empty cell still gets its end byte.
    wait_idle();
    configure(1, 2, 0, 255, 7, 7, 7, 7);
    send_cell(cell_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_cell(cell_of(8'hFF, 8'h01, 8'h10, 8'h00, 8'h00));
    send_cell(cell_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_cell(cell_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_cell(cell_of(8'h05, 8'h02, 8'h11, 8'h03, 8'h04));
    send_cell(cell_of(8'h05, 8'h02, 8'h11, 8'h03, 8'h04));

    // Random phases; the pattern position carries over from one phase to the
    // next, so later settings land mid-pattern.
    for (int ph = 0; ph < 12; ph++) begin
      wait_idle();
      n_items = $urandom_range(18, 26);
      case (ph)
        0: begin
          configure(0, 0, 0, 0, 0, 0, 0, 0);
          p_empty = 30;
        end
        1: begin
          configure(511, 63, 255, 255, 7, 7, 7, 7);
          p_empty = 20;
        end
        2: begin
          // one channel, long pattern, mostly empty: long row gaps
          configure(MAX_ROWS, 1, pick_code(), pick_code(), $urandom_range(0, 7),
                    $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
          p_empty = 95;
          n_items = 60;
        end
        default: begin
          configure(pick_rows(), pick_chans(), pick_code(), pick_code(),
                    $urandom_range(0, 7), $urandom_range(0, 7),
                    $urandom_range(0, 7), $urandom_range(0, 7));
          p_empty = $urandom_range(10, 60);
        end
      endcase

      burst_left = 0;
      for (int n = 0; n < n_items; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          if (gap > 0) hold_off(gap);
        end
        burst_left--;
        r = $urandom_range(0, 99);
        if (r < p_empty) kind = CELL_EMPTY;
        else if (r < p_empty + (100 - p_empty) / 3) kind = CELL_REPEAT;
        else if (r < p_empty + 2 * (100 - p_empty) / 3) kind = CELL_MIXED;
        else kind = CELL_RANDOM;
        send_cell(make_cell(kind, sb.chan_pos % MAX_CHANNELS));
      end
    end

    wait_idle();
    if (sb.fault_count == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(5_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule
